[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Every check is clocked on clk and is
// disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/stii_pkg.sv]
`timescale 1ns / 1ps

package stii_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_OUT_OF_RANGE = 2'd1;
  localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

endpackage

[hw/rtl/stii_req_if.sv]
`timescale 1ns / 1ps

interface stii_req_if;
  logic valid;
  logic ready;
  logic cmd;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;

  modport source (output valid, cmd, x_value, y_value, input ready);
  modport sink (input valid, cmd, x_value, y_value, output ready);
endinterface

[hw/rtl/stii_rsp_if.sv]
`timescale 1ns / 1ps

interface stii_rsp_if;
  logic valid;
  logic ready;
  logic signed [31:0] x_result;
  logic [1:0] status;

  modport source (output valid, x_result, status, input ready);
  modport sink (input valid, x_result, status, output ready);
endinterface

[hw/rtl/sorted_table_inverse_interpolator_core.sv]
// An insert walks down from the end of the table, moving each point with a larger key up by
// one entry until its place is found, and a full table answers table_full; a lookup scans
// from the first entry until a key is not below the query, then runs DIFF, ABS, MUL, 64
// divide steps in DIV and FIX; a query at or below the first key or above the last is out of range.
// A new item is taken only once the last result is registered; a result the sink has not taken
// holds the next one back. Synchronous reset empties the table; point memory is not cleared.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sorted_table_inverse_interpolator_core (
  input logic clk,
  input logic rst,
  stii_req_if.sink request,
  stii_rsp_if.source response
);

  typedef enum logic [3:0] {
    IDLE,
    INS_RD,
    INS_CMP,
    LK_RD,
    LK_CMP,
    DIFF,
    ABS,
    MUL,
    DIV,
    FIX,
    RESULT
  } state_t;

  state_t state;

  stii_pkg::point_t mem [stii_pkg::TABLE_DEPTH];
  stii_pkg::point_t rdata;
  stii_pkg::point_t wdata;
  logic mem_we;
  logic [stii_pkg::IDX_W-1:0] waddr;
  logic [stii_pkg::IDX_W-1:0] raddr;

  logic [stii_pkg::CNT_W-1:0] count;
  logic [stii_pkg::CNT_W-1:0] pos;
  logic [stii_pkg::CNT_W-1:0] pos_dec;

  logic signed [31:0] xv;
  logic signed [31:0] yv;

  stii_pkg::point_t lower;
  stii_pkg::point_t upper;
  logic signed [32:0] dx;
  logic [31:0] mag;
  logic [31:0] num;
  logic [31:0] den;

  logic [63:0] acc;
  logic [32:0] rem;
  logic [32:0] rem_sh;
  logic [33:0] trial;
  logic [stii_pkg::DIV_CNT_W-1:0] step;

  logic signed [31:0] res_x;
  logic [1:0] res_status;

  logic out_valid;
  logic signed [31:0] out_x;
  logic [1:0] out_status;

  assign request.ready = (state == IDLE);
  assign response.valid = out_valid;
  assign response.x_result = out_x;
  assign response.status = out_status;

  assign pos_dec = pos - stii_pkg::CNT_W'(1);
  assign rem_sh = {rem[31:0], acc[63]};
  assign trial = {1'b0, rem_sh} - {2'b00, den};

  always_comb begin
    mem_we = 1'b0;
    waddr = pos[stii_pkg::IDX_W-1:0];
    raddr = pos[stii_pkg::IDX_W-1:0];
    wdata = '{x: xv, y: yv};
    case (state)
      INS_RD: begin
        raddr = pos_dec[stii_pkg::IDX_W-1:0];
        if (pos == '0) begin
          mem_we = 1'b1;
        end
      end
      INS_CMP: begin
        mem_we = 1'b1;
        if (rdata.y > yv) begin
          wdata = rdata;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && response.ready && state != RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (request.valid) begin
            xv <= request.x_value;
            yv <= request.y_value;
            res_x <= '0;
            if (request.cmd == stii_pkg::CMD_PUT) begin
              if (count == stii_pkg::CNT_W'(stii_pkg::TABLE_DEPTH)) begin
                res_status <= stii_pkg::STATUS_TABLE_FULL;
                state <= RESULT;
              end else begin
                pos <= count;
                state <= INS_RD;
              end
            end else begin
              pos <= '0;
              state <= LK_RD;
            end
          end
        end
        INS_RD: begin
          if (pos == '0) begin
            count <= count + stii_pkg::CNT_W'(1);
            res_status <= stii_pkg::STATUS_OK;
            state <= RESULT;
          end else begin
            state <= INS_CMP;
          end
        end
        INS_CMP: begin
          if (rdata.y > yv) begin
            pos <= pos_dec;
            state <= INS_RD;
          end else begin
            count <= count + stii_pkg::CNT_W'(1);
            res_status <= stii_pkg::STATUS_OK;
            state <= RESULT;
          end
        end
        LK_RD: begin
          if (pos == count) begin
            res_status <= stii_pkg::STATUS_OUT_OF_RANGE;
            state <= RESULT;
          end else begin
            state <= LK_CMP;
          end
        end
        LK_CMP: begin
          if (rdata.y < yv) begin
            lower <= rdata;
            pos <= pos + stii_pkg::CNT_W'(1);
            state <= LK_RD;
          end else if (pos == '0) begin
            res_status <= stii_pkg::STATUS_OUT_OF_RANGE;
            state <= RESULT;
          end else begin
            upper <= rdata;
            state <= DIFF;
          end
        end
        DIFF: begin
          dx <= {upper.x[31], upper.x} - {lower.x[31], lower.x};
          num <= 32'(yv - lower.y);
          den <= 32'(upper.y - lower.y);
          state <= ABS;
        end
        ABS: begin
          mag <= dx[32] ? 32'(-dx) : dx[31:0];
          state <= MUL;
        end
        MUL: begin
          acc <= {32'd0, mag} * {32'd0, num};
          rem <= '0;
          step <= '0;
          state <= DIV;
        end
        DIV: begin
          if (!trial[33]) begin
            rem <= trial[32:0];
          end else begin
            rem <= rem_sh;
          end
          acc <= {acc[62:0], ~trial[33]};
          step <= step + stii_pkg::DIV_CNT_W'(1);
          if (step == stii_pkg::DIV_CNT_W'(stii_pkg::DIV_STEPS - 1)) begin
            state <= FIX;
          end
        end
        FIX: begin
          if (dx[32]) begin
            res_x <= lower.x - acc[31:0];
          end else begin
            res_x <= lower.x + acc[31:0];
          end
          res_status <= stii_pkg::STATUS_OK;
          state <= RESULT;
        end
        RESULT: begin
          if (!out_valid || response.ready) begin
            out_valid <= 1'b1;
            out_x <= res_x;
            out_status <= res_status;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `ASSERT_SAME(a_div_nonzero, state == DIV, den != '0, "division by zero span")
  `ASSERT_SAME(a_full_only_when_full,
    state == RESULT && res_status == stii_pkg::STATUS_TABLE_FULL,
    count == stii_pkg::CNT_W'(stii_pkg::TABLE_DEPTH), "table_full with room left")
  `ASSERT_SAME(a_error_zero, response.valid && response.status != stii_pkg::STATUS_OK,
    response.x_result == '0, "nonzero result on failed item")
  `ASSERT_NEXT(a_count_bound, state == INS_RD || state == INS_CMP,
    count <= stii_pkg::CNT_W'(stii_pkg::TABLE_DEPTH), "point count overflow")

endmodule
